FILE: hdl/iff_pkg.sv
package iff_pkg;

    // default cap on the requested field width
    localparam int MAX_FIELD_WIDTH_DEFAULT = 32;

    // fixed field widths
    localparam int CMD_W     = 2;
    localparam int VALUE_W   = 32;
    localparam int FW_W      = 6;
    localparam int CHAR_W    = 8;
    localparam int NDIG_W    = 4;
    localparam int NIB_W     = 4;
    localparam int MAG_EXT_W = VALUE_W + NDIG_W;
    localparam int HEX_DIGITS = VALUE_W / NIB_W;
    localparam int DEC_DIGITS = 10;

    // conversion codes
    typedef enum logic [CMD_W-1:0] {
        CMD_SDEC = 2'd0,
        CMD_UDEC = 2'd1,
        CMD_HEX  = 2'd2,
        CMD_CHAR = 2'd3
    } cmd_t;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_A_LOWER = 8'h61;

    // one formatted field, ready to be emitted
    typedef struct packed {
        cmd_t               cmd;
        logic [VALUE_W-1:0] mag;
        logic               neg;
        logic [NDIG_W-1:0]  ndig;
        logic [FW_W-1:0]    pre_cnt;
        logic [FW_W-1:0]    zero_cnt;
        logic [FW_W-1:0]    post_cnt;
    } field_t;

    // emitter status seen by the input stage
    typedef struct packed {
        logic busy;
        logic take;
    } emit_status_t;

    // powers of ten, widened so that nine times each still fits
    function automatic logic [MAG_EXT_W-1:0] pow10(input logic [NDIG_W-1:0] k);
        logic [MAG_EXT_W-1:0] p;
        case (k)
            4'd0:    p = 36'd1;
            4'd1:    p = 36'd10;
            4'd2:    p = 36'd100;
            4'd3:    p = 36'd1000;
            4'd4:    p = 36'd10000;
            4'd5:    p = 36'd100000;
            4'd6:    p = 36'd1000000;
            4'd7:    p = 36'd10000000;
            4'd8:    p = 36'd100000000;
            4'd9:    p = 36'd1000000000;
            default: p = '0;
        endcase
        return p;
    endfunction

    // lowercase hex digit
    function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
        logic [CHAR_W-1:0] c;
        if (nib < 4'd10)
            c = CH_ZERO + {4'b0000, nib};
        else
            c = CH_A_LOWER + {4'b0000, nib - 4'd10};
        return c;
    endfunction

endpackage

FILE: hdl/iff_measure.sv
module iff_measure #(
    parameter int MAX_FIELD_WIDTH = iff_pkg::MAX_FIELD_WIDTH_DEFAULT
) (
    input  iff_pkg::cmd_t                  cmd,
    input  logic [iff_pkg::VALUE_W-1:0]    mag,
    input  logic                           neg,
    input  logic [iff_pkg::FW_W-1:0]       field_width,
    input  logic                           zero_pad,
    input  logic                           left_align,
    output iff_pkg::field_t                field
);

    // cap as it can matter for a width port of this size
    localparam int FW_MAX = (1 << iff_pkg::FW_W) - 1;
    localparam logic [iff_pkg::FW_W-1:0] CAP =
        iff_pkg::FW_W'((MAX_FIELD_WIDTH > FW_MAX) ? FW_MAX : MAX_FIELD_WIDTH);

    logic [iff_pkg::NDIG_W-1:0] dec_n;
    logic [iff_pkg::NDIG_W-1:0] hex_n;
    logic [iff_pkg::NDIG_W-1:0] ndig;
    logic [iff_pkg::FW_W-1:0]   body;
    logic [iff_pkg::FW_W-1:0]   wcap;
    logic [iff_pkg::FW_W-1:0]   pad;

    // decimal digit count: one plus the powers of ten from ten upward not above the value
    always_comb
    begin
        dec_n = iff_pkg::NDIG_W'(1);
        for (int j = 1; j < iff_pkg::DEC_DIGITS; j++)
        begin
            if ({{iff_pkg::NDIG_W{1'b0}}, mag} >= iff_pkg::pow10(iff_pkg::NDIG_W'(j)))
                dec_n = dec_n + iff_pkg::NDIG_W'(1);
        end
    end

    // hex digit count: position of the top nonzero nibble
    always_comb
    begin
        hex_n = iff_pkg::NDIG_W'(1);
        for (int i = 0; i < iff_pkg::HEX_DIGITS; i++)
        begin
            if (mag[i*iff_pkg::NIB_W +: iff_pkg::NIB_W] != '0)
                hex_n = iff_pkg::NDIG_W'(i + 1);
        end
    end

    always_comb
    begin
        case (cmd)
            iff_pkg::CMD_SDEC: ndig = dec_n;
            iff_pkg::CMD_UDEC: ndig = dec_n;
            iff_pkg::CMD_HEX:  ndig = hex_n;
            default:           ndig = iff_pkg::NDIG_W'(1);
        endcase
    end

    // padding length and where it goes
    assign body = iff_pkg::FW_W'(ndig) + iff_pkg::FW_W'(neg);
    assign wcap = (field_width > CAP) ? CAP : field_width;
    assign pad  = (wcap > body) ? (wcap - body) : '0;

    always_comb
    begin
        field.cmd      = cmd;
        field.mag      = mag;
        field.neg      = neg;
        field.ndig     = ndig;
        field.pre_cnt  = (!left_align && !zero_pad) ? pad : '0;
        field.zero_cnt = (!left_align && zero_pad) ? pad : '0;
        field.post_cnt = left_align ? pad : '0;
    end

endmodule

FILE: hdl/iff_emitter.sv
module iff_emitter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  iff_pkg::field_t               field,
    output iff_pkg::emit_status_t         status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [iff_pkg::CHAR_W-1:0]    character,
    output logic                          last
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE,
        PH_SIGN,
        PH_ZERO,
        PH_DIGIT,
        PH_POST
    } phase_t;

    phase_t                        phase_reg, phase_next;
    iff_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [iff_pkg::VALUE_W-1:0]   mag_reg, mag_next;
    logic                          neg_reg, neg_next;
    logic [iff_pkg::NDIG_W-1:0]    dig_reg, dig_next;
    logic [iff_pkg::FW_W-1:0]      cnt_reg, cnt_next;
    logic [iff_pkg::FW_W-1:0]      zero_reg, zero_next;
    logic [iff_pkg::FW_W-1:0]      post_reg, post_next;
    logic [iff_pkg::CHAR_W-1:0]    char_reg, char_next;
    logic                          last_reg, last_next;
    logic                          valid_reg, valid_next;

    logic                          busy;
    logic                          adv;
    logic                          fin;
    logic [iff_pkg::NDIG_W-1:0]    k;
    logic [iff_pkg::MAG_EXT_W-1:0] p;
    logic [iff_pkg::MAG_EXT_W-1:0] sub;
    logic [iff_pkg::NDIG_W-1:0]    dec_d;
    logic [iff_pkg::NIB_W-1:0]     nib;
    logic [iff_pkg::CHAR_W-1:0]    dig_char;
    logic [iff_pkg::CHAR_W-1:0]    cur_char;
    logic                          cur_last;

    assign busy = (phase_reg != PH_IDLE);
    assign adv  = busy && (!valid_reg || !out_stall);
    assign fin  = adv && cur_last;

    assign status.busy = busy;
    assign status.take = !busy || fin;

    // leading decimal digit: compare against multiples one to nine of the current power
    assign k = dig_reg - iff_pkg::NDIG_W'(1);
    assign p = iff_pkg::pow10(k);

    always_comb
    begin
        dec_d = '0;
        sub   = '0;
        for (int m = 1; m < iff_pkg::DEC_DIGITS; m++)
        begin
            if ({{iff_pkg::NDIG_W{1'b0}}, mag_reg} >= p * iff_pkg::MAG_EXT_W'(m))
            begin
                dec_d = iff_pkg::NDIG_W'(m);
                sub   = p * iff_pkg::MAG_EXT_W'(m);
            end
        end
    end

    // leading hex digit
    assign nib = mag_reg[{k[2:0], 2'b00} +: iff_pkg::NIB_W];

    always_comb
    begin
        case (cmd_reg)
            iff_pkg::CMD_SDEC: dig_char = iff_pkg::CH_ZERO + {4'b0000, dec_d};
            iff_pkg::CMD_UDEC: dig_char = iff_pkg::CH_ZERO + {4'b0000, dec_d};
            iff_pkg::CMD_HEX:  dig_char = iff_pkg::hex_char(nib);
            default:           dig_char = mag_reg[iff_pkg::CHAR_W-1:0];
        endcase
    end

    // character of the current phase
    always_comb
    begin
        case (phase_reg)
            PH_PRE:   cur_char = iff_pkg::CH_BLANK;
            PH_SIGN:  cur_char = iff_pkg::CH_MINUS;
            PH_ZERO:  cur_char = iff_pkg::CH_ZERO;
            PH_DIGIT: cur_char = dig_char;
            PH_POST:  cur_char = iff_pkg::CH_BLANK;
            default:  cur_char = iff_pkg::CH_BLANK;
        endcase
    end

    assign cur_last = ((phase_reg == PH_DIGIT) && (dig_reg == iff_pkg::NDIG_W'(1))
                       && (post_reg == '0))
                   || ((phase_reg == PH_POST) && (cnt_reg == iff_pkg::FW_W'(1)));

    // phase sequencing: pre blanks, sign, zeros, digits, post blanks
    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        dig_next   = dig_reg;
        cnt_next   = cnt_reg;
        zero_next  = zero_reg;
        post_next  = post_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg;

        // output register
        if (adv)
        begin
            char_next  = cur_char;
            last_next  = cur_last;
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end

        if (load)
        begin
            cmd_next  = field.cmd;
            mag_next  = field.mag;
            neg_next  = field.neg;
            dig_next  = field.ndig;
            zero_next = field.zero_cnt;
            post_next = field.post_cnt;
            if (field.pre_cnt != '0)
            begin
                phase_next = PH_PRE;
                cnt_next   = field.pre_cnt;
            end
            else if (field.neg)
            begin
                phase_next = PH_SIGN;
            end
            else if (field.zero_cnt != '0)
            begin
                phase_next = PH_ZERO;
                cnt_next   = field.zero_cnt;
            end
            else
            begin
                phase_next = PH_DIGIT;
            end
        end
        else if (fin)
        begin
            phase_next = PH_IDLE;
        end
        else if (adv)
        begin
            case (phase_reg)
                PH_PRE:
                begin
                    cnt_next = cnt_reg - iff_pkg::FW_W'(1);
                    if (cnt_reg == iff_pkg::FW_W'(1))
                    begin
                        if (neg_reg)
                            phase_next = PH_SIGN;
                        else if (zero_reg != '0)
                        begin
                            phase_next = PH_ZERO;
                            cnt_next   = zero_reg;
                        end
                        else
                            phase_next = PH_DIGIT;
                    end
                end
                PH_SIGN:
                begin
                    if (zero_reg != '0)
                    begin
                        phase_next = PH_ZERO;
                        cnt_next   = zero_reg;
                    end
                    else
                        phase_next = PH_DIGIT;
                end
                PH_ZERO:
                begin
                    cnt_next = cnt_reg - iff_pkg::FW_W'(1);
                    if (cnt_reg == iff_pkg::FW_W'(1))
                        phase_next = PH_DIGIT;
                end
                PH_DIGIT:
                begin
                    if (cmd_reg == iff_pkg::CMD_SDEC || cmd_reg == iff_pkg::CMD_UDEC)
                        mag_next = mag_reg - sub[iff_pkg::VALUE_W-1:0];
                    dig_next = dig_reg - iff_pkg::NDIG_W'(1);
                    if (dig_reg == iff_pkg::NDIG_W'(1))
                    begin
                        phase_next = PH_POST;
                        cnt_next   = post_reg;
                    end
                end
                PH_POST:
                begin
                    cnt_next = cnt_reg - iff_pkg::FW_W'(1);
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // state and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            valid_reg <= 1'b0;
            cmd_reg   <= iff_pkg::CMD_SDEC;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            dig_reg   <= '0;
            cnt_reg   <= '0;
            zero_reg  <= '0;
            post_reg  <= '0;
            char_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
            cmd_reg   <= cmd_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            dig_reg   <= dig_next;
            cnt_reg   <= cnt_next;
            zero_reg  <= zero_next;
            post_reg  <= post_next;
            char_reg  <= char_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

FILE: hdl/integer_field_formatter.sv
// Formats one integer conversion request (signed decimal, unsigned decimal,
// lowercase hex or single character) into a padded ASCII field and sends it
// out one character per beat, with last set on the final character. A field
// holds max(text length, capped width) characters, sent one per cycle while
// out_stall is low; a waiting request follows the previous field with no gap.
// An accepted request passes the request register and the sequencer state
// registers before its first character reaches the output register. The
// request register takes the next request while the current field is being
// sent, and decimal digits come at that rate, most significant first, by
// comparing the remainder against the multiples of the current power of ten.
module integer_field_formatter #(
    parameter int MAX_FIELD_WIDTH = iff_pkg::MAX_FIELD_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [iff_pkg::CMD_W-1:0]     cmd,
    input  logic [iff_pkg::VALUE_W-1:0]   value,
    input  logic [iff_pkg::FW_W-1:0]      field_width,
    input  logic                          zero_pad,
    input  logic                          left_align,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [iff_pkg::CHAR_W-1:0]    character,
    output logic                          last
);

    iff_pkg::cmd_t               cmd_reg;
    logic [iff_pkg::VALUE_W-1:0] mag_reg;
    logic                        neg_reg;
    logic [iff_pkg::FW_W-1:0]    width_reg;
    logic                        zero_reg;
    logic                        left_reg;
    logic                        in_valid_reg, in_valid_next;

    iff_pkg::cmd_t               in_cmd;
    logic                        in_neg;
    logic [iff_pkg::VALUE_W-1:0] in_mag;
    logic                        accept;
    logic                        load;
    iff_pkg::field_t             field;
    iff_pkg::emit_status_t       emit_status;

    // sign and magnitude of the incoming beat
    assign in_cmd = iff_pkg::cmd_t'(cmd);
    assign in_neg = (in_cmd == iff_pkg::CMD_SDEC) && value[iff_pkg::VALUE_W-1];
    assign in_mag = in_neg ? (~value + iff_pkg::VALUE_W'(1)) : value;

    // request register handshake
    assign load     = in_valid_reg && emit_status.take;
    assign in_stall = in_valid_reg && !load;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (load)
            in_valid_next = 1'b0;
    end

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cmd_reg      <= iff_pkg::CMD_SDEC;
            mag_reg      <= '0;
            neg_reg      <= 1'b0;
            width_reg    <= '0;
            zero_reg     <= 1'b0;
            left_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (accept)
            begin
                cmd_reg   <= in_cmd;
                mag_reg   <= in_mag;
                neg_reg   <= in_neg;
                width_reg <= field_width;
                zero_reg  <= zero_pad;
                left_reg  <= left_align;
            end
        end
    end

    // digit count and padding
    iff_measure #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
    ) u_measure (
        .cmd         (cmd_reg),
        .mag         (mag_reg),
        .neg         (neg_reg),
        .field_width (width_reg),
        .zero_pad    (zero_reg),
        .left_align  (left_reg),
        .field       (field)
    );

    // character sequencer and output register
    iff_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .field     (field),
        .status    (emit_status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    // a loaded field always leaves the sequencer with characters to send
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> emit_status.busy)
        else $error("sequencer idle right after a field load");

    // a beat that is not the last one means the field is still in progress
    a_mid_field_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> emit_status.busy)
        else $error("field ended without a last beat");

    // a request waits only while the sequencer is occupied
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && emit_status.busy))
        else $error("request stalled with the sequencer free");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int FIELD_CAP = iff_pkg::MAX_FIELD_WIDTH_DEFAULT;
    localparam int RANDOM_REQS = 196;

    // one conversion request as presented on the input channel
    typedef struct packed {
        iff_pkg::cmd_t                cmd;
        logic [iff_pkg::VALUE_W-1:0]  value;
        logic [iff_pkg::FW_W-1:0]     width;
        logic                         zero_pad;
        logic                         left_align;
    } req_t;

    // one output beat: a character and its end-of-field mark
    typedef struct packed {
        logic [iff_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } char_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [iff_pkg::CHAR_W-1:0] character;
    logic last;
    req_t cur_req = '0;

    req_t pending_reqs[$];
    char_beat_t expected_chars[$];
    int total_reqs = 0;
    int accepted_count = 0;
    int error_count = 0;

    integer_field_formatter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cur_req.cmd),
        .value       (cur_req.value),
        .field_width (cur_req.width),
        .zero_pad    (cur_req.zero_pad),
        .left_align  (cur_req.left_align),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .character   (character),
        .last        (last)
    );

    always #6 clk = ~clk;

    // build the padded field for one request and queue its characters
    function automatic void predict_field(input req_t r);
        logic [iff_pkg::CHAR_W-1:0] text[$];
        logic [iff_pkg::CHAR_W-1:0] field[$];
        logic [iff_pkg::VALUE_W-1:0] mag;
        logic [iff_pkg::NIB_W-1:0] nib;
        logic neg;
        int unsigned cap;
        int unsigned body;
        int unsigned pad;
        char_beat_t beat;
        neg = 1'b0;
        mag = r.value;
        case (r.cmd)
            iff_pkg::CMD_SDEC, iff_pkg::CMD_UDEC:
            begin
                if (r.cmd == iff_pkg::CMD_SDEC && mag[iff_pkg::VALUE_W-1])
                begin
                    neg = 1'b1;
                    mag = -mag;
                end
                do
                begin
                    text.push_front(iff_pkg::CH_ZERO + 8'(mag % 10));
                    mag = mag / 10;
                end
                while (mag != 0);
            end
            iff_pkg::CMD_HEX:
            begin
                do
                begin
                    nib = mag[iff_pkg::NIB_W-1:0];
                    if (nib < 10)
                        text.push_front(iff_pkg::CH_ZERO + 8'(nib));
                    else
                        text.push_front(iff_pkg::CH_A_LOWER + 8'(nib - 10));
                    mag = mag >> iff_pkg::NIB_W;
                end
                while (mag != 0);
            end
            default:
                text.push_back(r.value[iff_pkg::CHAR_W-1:0]);
        endcase

        cap = (r.width > FIELD_CAP) ? FIELD_CAP : r.width;
        body = text.size() + (neg ? 1 : 0);
        pad = (cap > body) ? cap - body : 0;

        if (r.left_align)
        begin
            if (neg)
                field.push_back(iff_pkg::CH_MINUS);
            field = {field, text};
            repeat (pad) field.push_back(iff_pkg::CH_BLANK);
        end
        else if (r.zero_pad)
        begin
            if (neg)
                field.push_back(iff_pkg::CH_MINUS);
            repeat (pad) field.push_back(iff_pkg::CH_ZERO);
            field = {field, text};
        end
        else
        begin
            repeat (pad) field.push_back(iff_pkg::CH_BLANK);
            if (neg)
                field.push_back(iff_pkg::CH_MINUS);
            field = {field, text};
        end

        foreach (field[k])
        begin
            beat.ch = field[k];
            beat.last = (k == field.size() - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    task automatic add_req(input iff_pkg::cmd_t c,
                           input logic [iff_pkg::VALUE_W-1:0] v,
                           input int w, input bit zp, input bit la);
        req_t r;
        r.cmd = c;
        r.value = v;
        r.width = w[iff_pkg::FW_W-1:0];
        r.zero_pad = zp;
        r.left_align = la;
        pending_reqs.push_back(r);
    endtask

    // request sender: bursts of beats separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        int burst_left;
        int gap_left;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_field(cur_req);
                accepted_count++;
            end
            // a stalled beat stays as it is
            if (!(in_valid && in_stall))
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (gap_left != 0 || pending_reqs.size() == 0)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    cur_req <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    burst_left--;
                end
            end
        end
    end

    // character receiver: checks each beat and stalls on a repeating pattern
    always @(posedge clk or negedge rst_n)
    begin : watch_chars
        char_beat_t want;
        logic [15:0] stall_pattern;
        logic [3:0] pos;
        int window_left;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_pattern = '0;
            pos = '0;
            window_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected beat: character %h, last %b", character, last);
                    error_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (character !== want.ch)
                    begin
                        $error("character: expected %h, actual %h", want.ch, character);
                        error_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %b, actual %b", want.last, last);
                        error_count++;
                    end
                end
            end
            // pick a new stall pattern every window
            if (window_left == 0)
            begin
                window_left = $urandom_range(40, 120);
                case ($urandom_range(0, 3))
                    0: stall_pattern = '0;
                    1: stall_pattern = 16'($urandom & $urandom);
                    2: stall_pattern = 16'($urandom | $urandom);
                    default: stall_pattern = 16'($urandom);
                endcase
            end
            else
                window_left--;
            out_stall <= stall_pattern[pos];
            pos = pos + 1'b1;
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        iff_pkg::cmd_t c;
        logic [iff_pkg::VALUE_W-1:0] v;
        int w;
        int unsigned pw;

        // directed: extremes, every conversion, padding corners
        add_req(iff_pkg::CMD_SDEC, 32'd0, 0, 0, 0);
        add_req(iff_pkg::CMD_SDEC, 32'h8000_0000, 0, 0, 0);
        add_req(iff_pkg::CMD_SDEC, 32'h8000_0000, 14, 1, 0);
        add_req(iff_pkg::CMD_SDEC, 32'h7FFF_FFFF, 12, 0, 0);
        add_req(iff_pkg::CMD_SDEC, 32'hFFFF_FFFF, 5, 1, 0);
        add_req(iff_pkg::CMD_SDEC, -32'sd42, 8, 0, 1);
        add_req(iff_pkg::CMD_SDEC, -32'sd42, 8, 1, 1);
        add_req(iff_pkg::CMD_SDEC, 32'd123, 63, 0, 0);
        add_req(iff_pkg::CMD_SDEC, -32'sd7, 40, 1, 0);
        add_req(iff_pkg::CMD_UDEC, 32'hFFFF_FFFF, 0, 0, 0);
        add_req(iff_pkg::CMD_UDEC, 32'd4000000000, 12, 1, 0);
        add_req(iff_pkg::CMD_UDEC, 32'd800000000, 9, 0, 1);
        add_req(iff_pkg::CMD_UDEC, 32'd80000000, 3, 1, 0);
        add_req(iff_pkg::CMD_UDEC, 32'd9, 1, 0, 0);
        add_req(iff_pkg::CMD_HEX, 32'd0, 0, 0, 0);
        add_req(iff_pkg::CMD_HEX, 32'hFFFF_FFFF, 32, 1, 0);
        add_req(iff_pkg::CMD_HEX, 32'hDEAD_BEEF, 10, 0, 1);
        add_req(iff_pkg::CMD_HEX, 32'h0000_0001, 33, 1, 0);
        add_req(iff_pkg::CMD_HEX, 32'h0A0B_0C0D, 63, 1, 1);
        add_req(iff_pkg::CMD_CHAR, 32'h0000_0041, 0, 0, 0);
        add_req(iff_pkg::CMD_CHAR, 32'h0000_0000, 1, 0, 0);
        add_req(iff_pkg::CMD_CHAR, 32'hFFFF_FFFF, 4, 1, 0);
        add_req(iff_pkg::CMD_CHAR, 32'h0000_0080, 5, 0, 1);
        add_req(iff_pkg::CMD_CHAR, 32'h1234_567A, 32, 0, 0);

        // random requests, mostly short widths
        repeat (RANDOM_REQS)
        begin
            c = iff_pkg::cmd_t'($urandom_range(0, 3));
            case ($urandom_range(0, 4))
                0: v = $urandom;
                1: v = $urandom_range(0, 99);
                2:
                begin
                    // around a power of ten
                    pw = 1;
                    repeat ($urandom_range(0, 9)) pw = pw * 10;
                    v = pw + $urandom_range(0, 2) - 1;
                    if ($urandom_range(0, 1))
                        v = -v;
                end
                3: v = -$urandom_range(1, 1000);
                default: v = {1'b1, 31'($urandom)};
            endcase
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
            add_req(c, v, w, $urandom_range(0, 1), $urandom_range(0, 1));
        end
        total_reqs = pending_reqs.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_count < total_reqs)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
hdl/iff_pkg.sv
hdl/iff_measure.sv
hdl/iff_emitter.sv
hdl/integer_field_formatter.sv
sim/tb.sv
